/* src/fp32cz_pkg.sv */
// Shared types and constants for the binary32 chop/flush-to-zero arithmetic unit.
// Used by the add/multiply datapath, the divider pipeline and the top level.
`default_nettype none

package fp32cz_pkg;

	// Operation codes as they arrive on the opcode port.
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam int EXP_W   = 8;
	localparam int MAN_W   = 24;
	localparam int XEXP_W  = 11;
	localparam int NRM_W   = 55;
	localparam int ALN_W   = 80;
	localparam int SUM_W   = ALN_W + 1;
	localparam int GRD_W   = ALN_W - MAN_W;
	localparam int LZ_W    = 7;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = 15;
	localparam int QUO_W   = DIV_STEP * DIV_STAGES;

	localparam logic [EXP_W-1:0] EXP_ONES    = 8'hff;
	localparam logic [EXP_W-1:0] EXP_MAX_FIN = 8'hfe;
	localparam logic signed [XEXP_W-1:0] BIAS       = 11'sd127;
	localparam logic signed [XEXP_W-1:0] XEXP_TOP   = 11'sd254;
	localparam logic [30:0] MAX_MAG = 31'h7f7fffff;

	// Normalized intermediate: sig[54] is the leading one, sig[0] is a sticky bit.
	typedef struct packed {
		logic                     sign;
		logic                     zero;
		logic signed [XEXP_W-1:0] expo;
		logic [NRM_W-1:0]         sig;
	} nrm_t;

	// Side information that travels with a quotient through the divider.
	typedef struct packed {
		op_t                      op;
		logic                     sign;
		logic                     zero;
		logic                     divz;
		logic signed [XEXP_W-1:0] expo;
	} dtag_t;

endpackage

`default_nettype wire

/* src/fp32cz_div.sv */
// Pipelined restoring divider for 24-bit significands, four quotient bits per stage.
// Depends on fp32cz_pkg for widths and the divider side-information type.
`default_nettype none

module fp32cz_div
	import fp32cz_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [MAN_W-1:0] dividend,
	input  wire logic [MAN_W-1:0] divisor,
	input  wire dtag_t            tag_in,
	output logic [QUO_W-1:0]      quotient,
	output logic                  rem_nz,
	output dtag_t                 tag_out
);

	logic [MAN_W:0]   rem_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];
	logic [MAN_W-1:0] dvs_s [DIV_STAGES];
	dtag_t            tag_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [MAN_W:0]   rem_cur;
		logic [QUO_W-1:0] quo_cur;
		logic [MAN_W-1:0] dvs_cur;
		dtag_t            tag_cur;
		logic [MAN_W:0]   rem_nx;
		logic [QUO_W-1:0] quo_nx;

		if (g == 0) begin : g_first
			assign rem_cur = {1'b0, dividend};
			assign quo_cur = '0;
			assign dvs_cur = divisor;
			assign tag_cur = tag_in;
		end else begin : g_rest
			assign rem_cur = rem_s[g-1];
			assign quo_cur = quo_s[g-1];
			assign dvs_cur = dvs_s[g-1];
			assign tag_cur = tag_s[g-1];
		end

		// Several compare-and-subtract steps, each yielding one quotient bit.
		always_comb begin
			rem_nx = rem_cur;
			quo_nx = quo_cur;
			for (int k = 0; k < DIV_STEP; k++) begin
				if (rem_nx >= {1'b0, dvs_cur}) begin
					rem_nx = rem_nx - {1'b0, dvs_cur};
					quo_nx = {quo_nx[QUO_W-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[QUO_W-2:0], 1'b0};
				end
				rem_nx = {rem_nx[MAN_W-1:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				quo_s[g] <= quo_nx;
				dvs_s[g] <= dvs_cur;
				tag_s[g] <= tag_cur;
			end
		end
	end

	// The final remainder only matters as a sticky bit.
	assign quotient = quo_s[DIV_STAGES-1];
	assign rem_nz   = |rem_s[DIV_STAGES-1];
	assign tag_out  = tag_s[DIV_STAGES-1];

endmodule

`default_nettype wire

/* src/fp32cz_addmul.sv */
// Six-stage add/subtract and multiply datapath producing a normalized intermediate.
// Depends on fp32cz_pkg for widths, operation codes and the nrm_t type.
`default_nettype none

module fp32cz_addmul
	import fp32cz_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire op_t              op,
	input  wire logic             sa,
	input  wire logic             sb,
	input  wire logic [EXP_W-1:0] ea,
	input  wire logic [EXP_W-1:0] eb,
	input  wire logic [MAN_W-1:0] ma,
	input  wire logic [MAN_W-1:0] mb,
	output nrm_t                  res
);

	localparam int NCH   = 11;
	localparam int PAD_W = NCH * 8;

	// Stage 2 registers.
	logic [MAN_W-1:0]          big_s2, sml_s2;
	logic [EXP_W-1:0]          dsh_s2, ebig_s2;
	logic                      sbig_s2, sub_s2, zsgn_s2, mul_s2, smul_s2;
	logic [2*MAN_W-1:0]        prod_s2;
	logic signed [XEXP_W-1:0]  emul_s2;

	// Stage 3 registers.
	logic [MAN_W-1:0]          big_s3;
	logic [ALN_W-1:0]          sml_s3;
	logic [EXP_W-1:0]          ebig_s3;
	logic                      sbig_s3, sub_s3, zsgn_s3, mul_s3;
	nrm_t                      nmul_s3;

	// Stage 4 through 6 registers.
	logic [SUM_W-1:0]          sum_s4, sum_s5, sum_s6;
	logic [EXP_W-1:0]          ebig_s4, ebig_s5, ebig_s6;
	logic                      sbig_s4, sbig_s5, sbig_s6;
	logic                      zsgn_s4, zsgn_s5, zsgn_s6;
	logic                      mul_s4, mul_s5, mul_s6;
	nrm_t                      nmul_s4, nmul_s5, nmul_s6;
	logic [NCH-1:0]            cnz_s5;
	logic [2:0]                clz_s5 [NCH];
	logic [LZ_W-1:0]           lz_s6;
	logic                      zero_s6;

	// Output register.
	nrm_t                      res_s7;

	// Stage 1 to 2: order the addends by magnitude, form the raw product.
	logic sbe, a_ge;
	always_comb begin
		sbe  = sb ^ (op == OP_SUB);
		a_ge = {ea, ma} >= {eb, mb};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s2  <= a_ge ? ma : mb;
			sml_s2  <= a_ge ? mb : ma;
			ebig_s2 <= a_ge ? ea : eb;
			dsh_s2  <= a_ge ? (ea - eb) : (eb - ea);
			sbig_s2 <= a_ge ? sa : sbe;
			sub_s2  <= sa ^ sbe;
			zsgn_s2 <= sa & sbe;
			mul_s2  <= (op == OP_MUL);
			smul_s2 <= sa ^ sb;
			prod_s2 <= {{MAN_W{1'b0}}, ma} * {{MAN_W{1'b0}}, mb};
			emul_s2 <= $signed({3'b000, ea}) + $signed({3'b000, eb}) - BIAS;
		end
	end

	// Stage 2 to 3: align the smaller addend with sticky, normalize the product.
	logic [6:0]         dcl;
	logic [2*ALN_W-1:0] wide;
	logic [ALN_W-1:0]   sml_al;
	nrm_t               nmul_nx;
	always_comb begin
		dcl    = (dsh_s2 > 8'(ALN_W)) ? 7'(ALN_W) : dsh_s2[6:0];
		wide   = {sml_s2, {(2*ALN_W-MAN_W){1'b0}}} >> dcl;
		sml_al = {wide[2*ALN_W-1:ALN_W+1], wide[ALN_W] | (|wide[ALN_W-1:0])};
		nmul_nx.sign = smul_s2;
		nmul_nx.zero = (prod_s2 == '0);
		if (prod_s2[2*MAN_W-1]) begin
			nmul_nx.sig  = {prod_s2, 7'b0};
			nmul_nx.expo = emul_s2 + 11'sd1;
		end else begin
			nmul_nx.sig  = {prod_s2[2*MAN_W-2:0], 8'b0};
			nmul_nx.expo = emul_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s3  <= big_s2;
			sml_s3  <= sml_al;
			ebig_s3 <= ebig_s2;
			sbig_s3 <= sbig_s2;
			sub_s3  <= sub_s2;
			zsgn_s3 <= zsgn_s2;
			mul_s3  <= mul_s2;
			nmul_s3 <= nmul_nx;
		end
	end

	// Stage 3 to 4: magnitude add or subtract; the larger addend comes first, so the difference never goes negative.
	logic [SUM_W-1:0] big_ext;
	always_comb begin
		big_ext = {1'b0, big_s3, {GRD_W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= sub_s3 ? (big_ext - {1'b0, sml_s3}) : (big_ext + {1'b0, sml_s3});
			ebig_s4 <= ebig_s3;
			sbig_s4 <= sbig_s3;
			zsgn_s4 <= zsgn_s3;
			mul_s4  <= mul_s3;
			nmul_s4 <= nmul_s3;
		end
	end

	// Stage 4 to 5: leading-zero count of each byte of the sum.
	logic [PAD_W-1:0] padded;
	logic [7:0]       chk;
	logic [NCH-1:0]   cnz_nx;
	logic [2:0]       clz_nx [NCH];
	always_comb begin
		padded = {sum_s4, {(PAD_W-SUM_W){1'b0}}};
		for (int k = 0; k < NCH; k++) begin
			chk       = padded[PAD_W-1-8*k -: 8];
			cnz_nx[k] = |chk;
			clz_nx[k] = 3'd0;
			for (int j = 0; j < 8; j++) begin
				if (chk[j]) begin
					clz_nx[k] = 3'(7 - j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5  <= sum_s4;
			cnz_s5  <= cnz_nx;
			clz_s5  <= clz_nx;
			ebig_s5 <= ebig_s4;
			sbig_s5 <= sbig_s4;
			zsgn_s5 <= zsgn_s4;
			mul_s5  <= mul_s4;
			nmul_s5 <= nmul_s4;
		end
	end

	// Stage 5 to 6: the first nonzero byte gives the full count.
	logic [LZ_W-1:0] lz_nx;
	logic            zero_nx;
	always_comb begin
		lz_nx   = '0;
		zero_nx = 1'b1;
		for (int k = NCH - 1; k >= 0; k--) begin
			if (cnz_s5[k]) begin
				lz_nx   = 7'(k * 8) + 7'(clz_s5[k]);
				zero_nx = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6  <= sum_s5;
			lz_s6   <= lz_nx;
			zero_s6 <= zero_nx;
			ebig_s6 <= ebig_s5;
			sbig_s6 <= sbig_s5;
			zsgn_s6 <= zsgn_s5;
			mul_s6  <= mul_s5;
			nmul_s6 <= nmul_s5;
		end
	end

	// Stage 6 to 7: normalize the sum and choose between the two operations.
	logic [SUM_W-1:0] nsh;
	nrm_t             nadd;
	always_comb begin
		nsh        = sum_s6 << lz_s6;
		nadd.sig   = {nsh[SUM_W-1:SUM_W-NRM_W+1], |nsh[SUM_W-NRM_W:0]};
		nadd.expo  = $signed({3'b000, ebig_s6}) + 11'sd1 - $signed({4'b0000, lz_s6});
		nadd.zero  = zero_s6;
		nadd.sign  = zero_s6 ? zsgn_s6 : sbig_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s7 <= mul_s6 ? nmul_s6 : nadd;
		end
	end

	assign res = res_s7;

endmodule

`default_nettype wire

/* src/fp32_chop_ftz_arith_unit.sv */
// Top level of the binary32 chop/flush-to-zero arithmetic unit.
// Depends on fp32cz_pkg, fp32cz_addmul and fp32cz_div.
`default_nettype none

// Binary32 add, subtract, multiply and divide with denormal operands read as
// signed zero, infinities and NaNs read as signed maximum finite, results
// rounded to nearest-even at double precision and then truncated toward zero,
// overflow saturated and underflow flushed to signed zero. A zero or denormal
// divisor gives signed maximum finite. The unit is fully pipelined: it takes
// one operation every clock unless stalled and returns the results in order.
// The depth is set by the divider, which resolves four quotient bits per
// stage over fifteen stages; add, subtract and multiply travel through the
// same number of stages. A stall on the result side holds the whole pipeline
// and is passed straight back to the input side.
module fp32_chop_ftz_arith_unit
	import fp32cz_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result_bits
);

	localparam int DEPTH   = 18;
	localparam int AM_DLY  = DIV_STAGES - 6;

	logic [DEPTH-1:0] vld_s;
	logic             en;

	// The pipeline advances unless a finished result is held by the receiver.
	assign en        = !vld_s[DEPTH-1] || !out_stall;
	assign in_stall  = !en;
	assign out_valid = vld_s[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: read the operands with denormals as zero and specials as maximum.
	op_t              op_s1;
	logic             sa_s1, sb_s1, za_s1, zb_s1;
	logic [EXP_W-1:0] ea_s1, eb_s1;
	logic [MAN_W-1:0] ma_s1, mb_s1;
	logic [EXP_W-1:0] ea_nx, eb_nx;
	logic [MAN_W-1:0] ma_nx, mb_nx;

	always_comb begin
		unique case (operand_a[30:23])
			8'h00: begin
				ea_nx = '0;
				ma_nx = '0;
			end
			EXP_ONES: begin
				ea_nx = EXP_MAX_FIN;
				ma_nx = '1;
			end
			default: begin
				ea_nx = operand_a[30:23];
				ma_nx = {1'b1, operand_a[22:0]};
			end
		endcase
		unique case (operand_b[30:23])
			8'h00: begin
				eb_nx = '0;
				mb_nx = '0;
			end
			EXP_ONES: begin
				eb_nx = EXP_MAX_FIN;
				mb_nx = '1;
			end
			default: begin
				eb_nx = operand_b[30:23];
				mb_nx = {1'b1, operand_b[22:0]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_t'(opcode);
			sa_s1 <= operand_a[31];
			sb_s1 <= operand_b[31];
			za_s1 <= (operand_a[30:23] == 8'h00);
			zb_s1 <= (operand_b[30:23] == 8'h00);
			ea_s1 <= ea_nx;
			eb_s1 <= eb_nx;
			ma_s1 <= ma_nx;
			mb_s1 <= mb_nx;
		end
	end

	// Add, subtract and multiply path: result appears after stage 7.
	nrm_t am_s7;

	fp32cz_addmul u_addmul (
		.clk (clk),
		.en  (en),
		.op  (op_s1),
		.sa  (sa_s1),
		.sb  (sb_s1),
		.ea  (ea_s1),
		.eb  (eb_s1),
		.ma  (ma_s1),
		.mb  (mb_s1),
		.res (am_s7)
	);

	// Divide path: result appears after stage 16.
	dtag_t            tag_s1;
	dtag_t            tag_s16;
	logic [QUO_W-1:0] quo_s16;
	logic             rnz_s16;

	always_comb begin
		tag_s1.op   = op_s1;
		tag_s1.sign = sa_s1 ^ sb_s1;
		tag_s1.zero = za_s1;
		tag_s1.divz = zb_s1 && (op_s1 == OP_DIV);
		tag_s1.expo = $signed({3'b000, ea_s1}) - $signed({3'b000, eb_s1}) + BIAS;
	end

	fp32cz_div u_div (
		.clk      (clk),
		.en       (en),
		.dividend (ma_s1),
		.divisor  (mb_s1),
		.tag_in   (tag_s1),
		.quotient (quo_s16),
		.rem_nz   (rnz_s16),
		.tag_out  (tag_s16)
	);

	// Delay the add/multiply result to meet the quotient.
	nrm_t am_dly_s [AM_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			am_dly_s[0] <= am_s7;
			for (int k = 1; k < AM_DLY; k++) begin
				am_dly_s[k] <= am_dly_s[k-1];
			end
		end
	end

	// Stage 17: select the path and find whether double rounding carries into bit 24.
	nrm_t                     fin;
	logic                     sat_nx, rup, inc_nx;
	logic                     sgn_s17, zero_s17, sat_s17, inc_s17;
	logic signed [XEXP_W-1:0] exp_s17;
	logic [MAN_W-1:0]         man_s17;

	always_comb begin
		if (tag_s16.op == OP_DIV) begin
			fin.sign = tag_s16.sign;
			fin.zero = tag_s16.zero;
			if (quo_s16[QUO_W-1]) begin
				fin.sig  = {quo_s16[QUO_W-1:QUO_W-NRM_W+1],
					(|quo_s16[QUO_W-NRM_W:0]) | rnz_s16};
				fin.expo = tag_s16.expo;
			end else begin
				fin.sig  = {quo_s16[QUO_W-2:QUO_W-NRM_W],
					(|quo_s16[QUO_W-NRM_W-1:0]) | rnz_s16};
				fin.expo = tag_s16.expo - 11'sd1;
			end
		end else begin
			fin = am_dly_s[AM_DLY-1];
		end
		sat_nx = tag_s16.divz;
		rup    = fin.sig[1] & (fin.sig[0] | fin.sig[2]);
		inc_nx = rup & (&fin.sig[30:2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s17  <= fin.sign;
			zero_s17 <= fin.zero;
			sat_s17  <= sat_nx;
			inc_s17  <= inc_nx;
			exp_s17  <= fin.expo;
			man_s17  <= fin.sig[NRM_W-1:NRM_W-MAN_W];
		end
	end

	// Stage 18: apply the carry, then saturate or flush and pack.
	logic [MAN_W:0]           msum;
	logic signed [XEXP_W-1:0] efin;
	logic [31:0]              res_nx;
	logic [31:0]              res_s18;

	always_comb begin
		msum = {1'b0, man_s17} + {{MAN_W{1'b0}}, inc_s17};
		efin = exp_s17 + $signed({{(XEXP_W-1){1'b0}}, msum[MAN_W]});
		priority if (sat_s17) begin
			res_nx = {sgn_s17, MAX_MAG};
		end else if (zero_s17) begin
			res_nx = {sgn_s17, 31'h0};
		end else if (efin > XEXP_TOP) begin
			res_nx = {sgn_s17, MAX_MAG};
		end else if (efin < 11'sd1) begin
			res_nx = {sgn_s17, 31'h0};
		end else begin
			res_nx = {sgn_s17, efin[EXP_W-1:0], msum[MAN_W-2:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s18 <= res_nx;
		end
	end

	assign result_bits = res_s18;

endmodule

`default_nettype wire
